// ===== hw/rtl/hexfl_pkg.sv =====
// shared types and constants for the hex float text converter
package hexfl_pkg;

	typedef enum logic [2:0] {
		PH_START = 3'd0,
		PH_SIGN  = 3'd1,
		PH_ZERO  = 3'd2,
		PH_INT   = 3'd3,
		PH_FRAC  = 3'd4,
		PH_EXP0  = 3'd5,
		PH_EXPB  = 3'd6,
		PH_BAD   = 3'd7
	} phase_t;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_EMPTY   = 3'd1;
	localparam logic [2:0] ST_INVALID = 3'd2;
	localparam logic [2:0] ST_RANGE   = 3'd3;
	localparam logic [2:0] ST_DECIMAL = 3'd4;

	localparam int KEEP_BITS = 54;

	typedef struct packed {
		logic hex;
		logic saw;
		logic allow;
		logic pend;
		logic eneg;
		logic edig;
	} flags_t;

	// lowercase letter of each special word at a position
	function automatic logic [7:0] nan_char(input logic [3:0] wp);
		logic [7:0] r;
		unique case (wp)
			4'd0: r = 8'h6e;
			4'd1: r = 8'h61;
			4'd2: r = 8'h6e;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] inf_char(input logic [3:0] wp);
		logic [7:0] r;
		unique case (wp)
			4'd0: r = 8'h69;
			4'd1: r = 8'h6e;
			4'd2: r = 8'h66;
			4'd3: r = 8'h69;
			4'd4: r = 8'h6e;
			4'd5: r = 8'h69;
			4'd6: r = 8'h74;
			4'd7: r = 8'h79;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/hex_float_text_to_ieee_bits.sv =====
// top level: hexadecimal float text to ieee binary32/binary64 bits
//
// channel | dir | handshake            | payload
// in      | in  | in_valid / in_ready  | char_code, last_char, empty_string
// out     | out | out_valid / out_ready| status, float_bits
// cfg     | in  | cfg_valid / cfg_ready| cfg_data (format_select)
//
// one character item per cycle; the scanner updates its state in the accept cycle
// an ending item's finished text state is classified and captured in the _s1 registers
// at its accept edge; from there it is rounded into the result register
// so out_valid rises as the item leaves _s1; items flow back to back while not stalled
// stalls: in_ready drops only while _s1 holds an item and the result register is not taken
// arst_n clears all text state and format_select to binary32
module hex_float_text_to_ieee_bits #(
	parameter int EXP_ACC_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_code,
	input  logic        last_char,
	input  logic        empty_string,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [63:0] float_bits,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data
);
	localparam int W = EXP_ACC_BITS;

	logic fmt_q;
	logic acc, ends, adv, adv_out;

	// the text state as it stands after this item's character
	hexfl_pkg::phase_t ph;
	hexfl_pkg::flags_t fl;
	logic nan_ok, inf_ok, neg, sticky;
	logic [3:0] wp;
	logic [53:0] kept;
	logic [5:0] kcnt;
	logic signed [W-1:0] bpos;
	logic [W-2:0] wexp;

	// classification of the finished text
	logic conv_c, zero_c;
	logic [2:0] st_c;
	logic [63:0] pre_c;
	logic [53:0] m_c;
	logic signed [W-1:0] e_c;

	// stage 1: classified end-of-text snapshot
	logic v_s1, conv_s1, dbl_s1, neg_s1, zero_s1, stk_s1;
	logic [2:0] st_s1;
	logic [63:0] pre_s1;
	logic [53:0] m_s1;
	logic signed [W-1:0] e_s1;
	logic [2:0] rnd_st;
	logic [63:0] rnd_bits;

	assign cfg_ready = 1'b1;
	// result register free, or being emptied this cycle
	assign adv_out = !out_valid || out_ready;
	// _s1 free, or moving on into the result register
	assign adv = !v_s1 || adv_out;
	assign in_ready = adv;
	assign acc = in_valid && in_ready;
	assign ends = acc && (empty_string || last_char);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fmt_q <= 1'b0;
		else if (cfg_valid && cfg_ready) fmt_q <= cfg_data;
	end

	// an empty item carries no character, an ending item clears the text state
	hexfl_scan #(.EXP_ACC_BITS(EXP_ACC_BITS)) u_scan (
		.clk(clk), .arst_n(arst_n), .step(acc), .has_char(!empty_string),
		.ch(char_code), .clear(ends), .phase_v(ph), .nan_ok_v(nan_ok),
		.inf_ok_v(inf_ok), .wp_v(wp), .neg_v(neg), .flags_v(fl), .kept_v(kept),
		.kcnt_v(kcnt), .sticky_v(sticky), .bpos_v(bpos), .wexp_v(wexp)
	);

	// classification; word matches win over syntax, format is read at the text's end
	always_comb begin
		logic signed [W:0] es;
		logic signed [W-1:0] we;
		st_c = hexfl_pkg::ST_INVALID;
		pre_c = '0;
		conv_c = 1'b0;
		we = fl.eneg ? -$signed({1'b0, wexp}) : $signed({1'b0, wexp});
		es = {bpos[W-1], bpos} + {we[W-1], we};
		if (ph == hexfl_pkg::PH_START) st_c = hexfl_pkg::ST_EMPTY;
		else if (nan_ok && wp == 4'd3) begin
			st_c = hexfl_pkg::ST_OK;
			pre_c = fmt_q ? 64'h7FF8_0000_0000_0000 : 64'h7FC0_0000;
		end else if (inf_ok && (wp == 4'd3 || wp == 4'd8)) begin
			st_c = hexfl_pkg::ST_OK;
			pre_c = fmt_q ? {neg, 63'h7FF0_0000_0000_0000} : {32'd0, neg, 31'h7F80_0000};
		end else if (ph == hexfl_pkg::PH_BAD || fl.pend) st_c = hexfl_pkg::ST_INVALID;
		else if (ph == hexfl_pkg::PH_ZERO) st_c = hexfl_pkg::ST_DECIMAL;
		else if (ph == hexfl_pkg::PH_INT || ph == hexfl_pkg::PH_FRAC)
			st_c = (!fl.hex && fl.saw) ? hexfl_pkg::ST_DECIMAL : hexfl_pkg::ST_INVALID;
		else if (ph == hexfl_pkg::PH_EXPB && fl.edig) begin
			if (fl.hex) conv_c = 1'b1;
			else st_c = hexfl_pkg::ST_DECIMAL;
		end
		zero_c = kcnt == 6'd0;
		// leading one moved up to bit 53
		m_c = kept << (6'd54 - kcnt);
		// exponent of the leading one, saturating at the accumulator width
		if (es > $signed({1'b0, {(W-1){1'b1}}})) e_c = {1'b0, {(W-1){1'b1}}};
		else if (es < $signed({2'b11, {(W-1){1'b0}}})) e_c = {1'b1, {(W-1){1'b0}}};
		else e_c = es[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= ends;
	end
	always_ff @(posedge clk) begin
		if (ends) begin
			conv_s1 <= conv_c;
			st_s1 <= st_c;
			pre_s1 <= pre_c;
			dbl_s1 <= fmt_q;
			neg_s1 <= neg;
			zero_s1 <= zero_c;
			stk_s1 <= sticky;
			m_s1 <= m_c;
			e_s1 <= e_c;
		end
	end

	hexfl_round #(.EXP_ACC_BITS(EXP_ACC_BITS)) u_round (
		.dbl(dbl_s1), .neg(neg_s1), .m(m_s1), .zero_sig(zero_s1), .sticky_in(stk_s1),
		.e(e_s1), .status(rnd_st), .bits(rnd_bits)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv_out) out_valid <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (adv_out && v_s1) begin
			status <= conv_s1 ? rnd_st : st_s1;
			float_bits <= conv_s1 ? rnd_bits : pre_s1;
		end
	end
endmodule

// ===== hw/rtl/hexfl_scan.sv =====
// per-character scanner: syntax state, special words, significand and exponent accumulation
module hexfl_scan #(
	parameter int EXP_ACC_BITS = 24
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  logic                    has_char,
	input  logic [7:0]              ch,
	input  logic                    clear,
	output hexfl_pkg::phase_t       phase_v,
	output logic                    nan_ok_v,
	output logic                    inf_ok_v,
	output logic [3:0]              wp_v,
	output logic                    neg_v,
	output hexfl_pkg::flags_t       flags_v,
	output logic [53:0]             kept_v,
	output logic [5:0]              kcnt_v,
	output logic                    sticky_v,
	output logic signed [EXP_ACC_BITS-1:0] bpos_v,
	output logic [EXP_ACC_BITS-2:0] wexp_v
);
	localparam int W = EXP_ACC_BITS;
	localparam logic signed [W-1:0] AMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] AMIN = {1'b1, {(W-1){1'b0}}};

	hexfl_pkg::phase_t phase_q;
	hexfl_pkg::flags_t flags_q;
	logic nan_ok_q, inf_ok_q, neg_q, sticky_q;
	logic [3:0] wp_q;
	logic [53:0] kept_q;
	logic [5:0] kcnt_q;
	logic signed [W-1:0] bpos_q;
	logic [W-2:0] wexp_q;

	hexfl_pkg::phase_t ph_d;
	hexfl_pkg::flags_t fl_d;
	logic nan_d, inf_d, neg_d, sticky_d;
	logic [3:0] wp_d;
	logic [53:0] kept_d;
	logic [5:0] kcnt_d;
	logic signed [W-1:0] bpos_d;
	logic [W-2:0] wexp_d;

	logic [7:0] lc;
	logic is_dec, is_hexd, hex, pm;
	logic [3:0] dv;

	function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
		input logic signed [3:0] b);
		logic signed [W:0] s;
		s = {a[W-1], a} + {{(W-3){b[3]}}, b};
		if (s > $signed({AMAX[W-1], AMAX})) return AMAX;
		if (s < $signed({AMIN[W-1], AMIN})) return AMIN;
		return s[W-1:0];
	endfunction

	always_comb begin
		logic [2:0] n;
		logic [W+2:0] ten;
		logic fed, frac, dig_int, done;
		hexfl_pkg::phase_t ph;
		ph_d = phase_q; fl_d = flags_q; nan_d = nan_ok_q; inf_d = inf_ok_q;
		wp_d = wp_q; neg_d = neg_q; kept_d = kept_q; kcnt_d = kcnt_q;
		sticky_d = sticky_q; bpos_d = bpos_q; wexp_d = wexp_q;
		lc = (ch >= 8'h41 && ch <= 8'h5a) ? ch + 8'd32 : ch;
		is_dec = ch >= 8'h30 && ch <= 8'h39;
		hex = flags_q.hex;
		is_hexd = is_dec || (lc >= 8'h61 && lc <= 8'h66);
		dv = is_dec ? ch[3:0] : lc[3:0] + 4'd9;
		pm = ch == 8'h2b || ch == 8'h2d;
		fed = 1'b0; frac = 1'b0; n = 3'd4; ten = '0;
		dig_int = 1'b0; done = 1'b0;
		// special words
		if (phase_q == hexfl_pkg::PH_START && pm) begin
			nan_d = 1'b0;
		end else begin
			if (!(wp_q < 4'd3 && lc == hexfl_pkg::nan_char(wp_q))) nan_d = 1'b0;
			if (!(wp_q < 4'd8 && lc == hexfl_pkg::inf_char(wp_q))) inf_d = 1'b0;
			if (wp_q != 4'd15) wp_d = wp_q + 4'd1;
		end
		// syntax
		ph = phase_q;
		if (ph != hexfl_pkg::PH_BAD) begin
			if (ph == hexfl_pkg::PH_START) begin
				if (pm) begin
					neg_d = ch == 8'h2d; ph_d = hexfl_pkg::PH_SIGN; done = 1'b1;
				end else ph = hexfl_pkg::PH_SIGN;
			end
			if (!done && ph == hexfl_pkg::PH_SIGN) begin
				if (ch == 8'h30) begin
					ph_d = hexfl_pkg::PH_ZERO; done = 1'b1;
				end else ph = hexfl_pkg::PH_INT;
			end else if (!done && ph == hexfl_pkg::PH_ZERO) begin
				if (lc == 8'h78) begin
					fl_d.hex = 1'b1; fl_d.allow = 1'b1;
					ph_d = hexfl_pkg::PH_INT; done = 1'b1;
				end else begin
					fl_d.saw = 1'b1; fl_d.allow = 1'b1; ph = hexfl_pkg::PH_INT;
				end
			end
			if (!done && (ph == hexfl_pkg::PH_INT || ph == hexfl_pkg::PH_FRAC)) begin
				done = 1'b1;
				ph_d = ph;
				if (is_dec || (hex && is_hexd)) begin
					fed = hex; frac = ph == hexfl_pkg::PH_FRAC;
					fl_d.saw = 1'b1; fl_d.allow = 1'b1; fl_d.pend = 1'b0;
				end else if (fl_d.pend) ph_d = hexfl_pkg::PH_BAD;
				else if (ch == 8'h5f) begin
					if (!fl_d.allow) ph_d = hexfl_pkg::PH_BAD;
					else begin fl_d.allow = 1'b0; fl_d.pend = 1'b1; end
				end else if (ph == hexfl_pkg::PH_INT && ch == 8'h2e) begin
					fl_d.allow = 1'b0; ph_d = hexfl_pkg::PH_FRAC;
				end else if (!fl_d.saw || lc != (hex ? 8'h70 : 8'h65))
					ph_d = hexfl_pkg::PH_BAD;
				else begin
					fl_d.allow = 1'b0; ph_d = hexfl_pkg::PH_EXP0;
				end
			end
			if (!done && ph == hexfl_pkg::PH_EXP0) begin
				ph_d = hexfl_pkg::PH_EXPB;
				if (pm) begin
					if (ch == 8'h2d) fl_d.eneg = 1'b1;
					done = 1'b1;
				end
			end
			if (!done) begin
				if (is_dec) begin
					dig_int = 1'b1;
					fl_d.edig = 1'b1; fl_d.allow = 1'b1; fl_d.pend = 1'b0;
				end else if (ch == 8'h5f && !fl_d.pend && fl_d.allow) begin
					fl_d.allow = 1'b0; fl_d.pend = 1'b1;
				end else ph_d = hexfl_pkg::PH_BAD;
			end
		end
		// exponent accumulation, saturating
		if (dig_int) begin
			ten = {3'b000, wexp_q, 1'b0} + {1'b0, wexp_q, 3'b000} + {{(W-1){1'b0}}, ch[3:0]};
			wexp_d = (ten > {3'b000, AMAX}) ? AMAX[W-2:0] : ten[W-2:0];
		end
		// significand
		if (fed) begin
			if (kcnt_q == 6'd0) begin
				if (frac) bpos_d = sat_add(bpos_d, -4'sd4);
				n = dv[3] ? 3'd4 : dv[2] ? 3'd3 : dv[1] ? 3'd2 : 3'd1;
				if (dv != 4'd0) bpos_d = sat_add(bpos_d, $signed({1'b0, n}) - 4'sd1);
				else n = 3'd0;
			end else if (!frac) bpos_d = sat_add(bpos_d, 4'sd4);
			for (int i = 3; i >= 0; i--) begin
				if (i < int'(n)) begin
					if (kcnt_d < 6'(hexfl_pkg::KEEP_BITS)) begin
						kept_d = {kept_d[52:0], dv[i]};
						kcnt_d = kcnt_d + 6'd1;
					end else sticky_d = sticky_d | dv[i];
				end
			end
		end
	end

	// state as it stands after this item's character, if it carries one
	assign phase_v  = has_char ? ph_d : phase_q;
	assign nan_ok_v = has_char ? nan_d : nan_ok_q;
	assign inf_ok_v = has_char ? inf_d : inf_ok_q;
	assign wp_v     = has_char ? wp_d : wp_q;
	assign neg_v    = has_char ? neg_d : neg_q;
	assign flags_v  = has_char ? fl_d : flags_q;
	assign kept_v   = has_char ? kept_d : kept_q;
	assign kcnt_v   = has_char ? kcnt_d : kcnt_q;
	assign sticky_v = has_char ? sticky_d : sticky_q;
	assign bpos_v   = has_char ? bpos_d : bpos_q;
	assign wexp_v   = has_char ? wexp_d : wexp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hexfl_pkg::PH_START; nan_ok_q <= 1'b1; inf_ok_q <= 1'b1;
			wp_q <= '0; neg_q <= 1'b0; flags_q <= '0; kept_q <= '0; kcnt_q <= '0;
			sticky_q <= 1'b0; bpos_q <= '0; wexp_q <= '0;
		end else if (clear) begin
			phase_q <= hexfl_pkg::PH_START; nan_ok_q <= 1'b1; inf_ok_q <= 1'b1;
			wp_q <= '0; neg_q <= 1'b0; flags_q <= '0; kept_q <= '0; kcnt_q <= '0;
			sticky_q <= 1'b0; bpos_q <= '0; wexp_q <= '0;
		end else if (step && has_char) begin
			phase_q <= ph_d; nan_ok_q <= nan_d; inf_ok_q <= inf_d; wp_q <= wp_d;
			neg_q <= neg_d; flags_q <= fl_d; kept_q <= kept_d; kcnt_q <= kcnt_d;
			sticky_q <= sticky_d; bpos_q <= bpos_d; wexp_q <= wexp_d;
		end
	end
endmodule

// ===== hw/rtl/hexfl_round.sv =====
// end-of-text stage 2: rounding to binary32 or binary64 and result assembly
module hexfl_round #(
	parameter int EXP_ACC_BITS = 24
) (
	input  logic                           dbl,
	input  logic                           neg,
	input  logic [53:0]                    m,
	input  logic                           zero_sig,
	input  logic                           sticky_in,
	input  logic signed [EXP_ACC_BITS-1:0] e,
	output logic [2:0]                     status,
	output logic [63:0]                    bits
);
	localparam int W = EXP_ACC_BITS;

	always_comb begin
		logic signed [W+1:0] ee, min_e, max_e, keep;
		logic [6:0] p, r;
		logic [54:0] sig, lead;
		logic rnd, stk;
		logic [63:0] sign, mask;
		logic [10:0] bexp;
		p = dbl ? 7'd53 : 7'd24;
		min_e = dbl ? -(W+2)'(1022) : -(W+2)'(126);
		max_e = dbl ? (W+2)'(1023) : (W+2)'(127);
		ee = (W+2)'(e);
		sign = neg ? (dbl ? 64'h8000_0000_0000_0000 : 64'h8000_0000) : 64'd0;
		lead = 55'd1 << (p - 7'd1);
		status = hexfl_pkg::ST_OK;
		bits = sign;
		keep = '0; r = '0; sig = '0; rnd = 1'b0; stk = 1'b0; mask = '0; bexp = '0;
		if (!zero_sig) begin
			if (ee > max_e) begin
				status = hexfl_pkg::ST_RANGE; bits = '0;
			end else begin
				keep = (ee >= min_e) ? (W+2)'(p) : ee - min_e + (W+2)'(p);
				if (keep >= 0) begin
					r = 7'd53 - keep[6:0];
					sig = 55'({1'b0, m} >> (r + 7'd1));
					rnd = m[r[5:0]];
					mask = (64'd1 << r) - 64'd1;
					stk = |(m & mask[53:0]) || sticky_in;
					if (rnd && (stk || sig[0])) sig = sig + 55'd1;
					if (ee < min_e) bits = sign | 64'(sig);
					else if (sig == (lead << 1)) begin
						if (ee + 1 > max_e) begin
							status = hexfl_pkg::ST_RANGE; bits = '0;
						end else begin
							bexp = 11'(ee + 1 + (dbl ? 1023 : 127));
							bits = sign | (64'(bexp) << (p - 7'd1));
						end
					end else begin
						bexp = 11'(ee + (dbl ? 1023 : 127));
						bits = sign | (64'(bexp) << (p - 7'd1)) | 64'(sig - lead);
					end
				end
			end
		end
	end
endmodule
